// File: hdl/dqsd_pkg.sv
// shared types and constants for the double-ended queue with search and delete
// no dependencies; imported by dqsd_engine, deque_with_search_delete and the testbench
package dqsd_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_DELETE     = 2'd2,
        CMD_FIND       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
    } res_t;

endpackage

// File: hdl/dqsd_ram.sv
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module dqsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/dqsd_engine.sv
// command sequencer: head and count registers, scan for find and delete,
// read-modify-write shift that closes the gap; drives the entry ram
// depends on dqsd_pkg
module dqsd_engine #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dqsd_pkg::cmd_t                in_cmd,
    input  logic [dqsd_pkg::VALUE_W-1:0]  in_value,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dqsd_pkg::res_t                res,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [dqsd_pkg::VALUE_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [dqsd_pkg::VALUE_W-1:0]  ram_rdata
);

    import dqsd_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam int CW  = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pidx_reg, pidx_next;
    logic                 rd_vld_reg, rd_vld_next;
    status_t              status_reg, status_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    logic                 accept;
    logic                 is_push;
    logic                 full;
    logic                 empty;
    logic                 hit;
    logic                 last_rd;
    logic                 issue;
    logic                 hit_is_last;
    logic [CW+POS_W-1:0]  pidx_ext;
    logic [AW-1:0]        head_dec;

    // physical slot of a logical position, head + pos wrapped once
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [AW:0] s;
        s = AW1'(head) + AW1'(pos);
        if (s >= AW1'(DEPTH))
        begin
            s = s - AW1'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign accept      = in_valid && in_ready;
    assign is_push     = (in_cmd == CMD_PUSH_FRONT) || (in_cmd == CMD_PUSH_BACK);
    assign full        = (count_reg == CW'(DEPTH));
    assign empty       = (count_reg == '0);
    assign hit         = rd_vld_reg && (ram_rdata == val_reg);
    assign last_rd     = rd_vld_reg && (pidx_reg == count_reg - CW'(1));
    assign issue       = (idx_reg < count_reg);
    assign hit_is_last = (pidx_reg + CW'(1) == count_reg);
    assign pidx_ext    = {{POS_W{1'b0}}, pidx_reg};
    assign head_dec    = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_push || empty)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg == CMD_DELETE && !hit_is_last)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (last_rd)
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                if (last_rd)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and ram control
    always_comb
    begin
        in_ready     = (state_reg == S_IDLE);
        res_valid    = (state_reg == S_RESP);
        res.status   = status_reg;
        res.position = pos_reg;
        ram_re       = ((state_reg == S_SCAN) || (state_reg == S_SHIFT)) && issue;
        ram_raddr    = slot_of(head_reg, idx_reg);
        ram_we       = 1'b0;
        ram_waddr    = slot_of(head_reg, pidx_reg - CW'(1));
        ram_wdata    = ram_rdata;
        if (state_reg == S_IDLE)
        begin
            ram_we    = accept && is_push && !full;
            ram_wdata = in_value;
            ram_waddr = (in_cmd == CMD_PUSH_FRONT) ? head_dec
                                                   : slot_of(head_reg, count_reg);
        end
        else if (state_reg == S_SHIFT)
        begin
            // entry read last cycle moves up one place
            ram_we = rd_vld_reg;
        end
    end

    // datapath registers
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        pidx_next   = pidx_reg;
        rd_vld_next = 1'b0;
        status_next = status_reg;
        pos_next    = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = in_cmd;
                    val_next    = in_value;
                    idx_next    = '0;
                    pos_next    = '0;
                    status_next = ST_OK;
                    if (is_push)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            if (in_cmd == CMD_PUSH_FRONT)
                            begin
                                head_next = head_dec;
                            end
                        end
                    end
                    else if (empty)
                    begin
                        status_next = ST_MISSING;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pidx_next = idx_reg;
                end
                rd_vld_next = issue && !hit && !last_rd;
                if (hit)
                begin
                    status_next = ST_OK;
                    if (cmd_reg == CMD_FIND)
                    begin
                        pos_next = pidx_ext[POS_W-1:0];
                    end
                    else if (hit_is_last)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        // restart reads just behind the match
                        idx_next  = pidx_reg + CW'(1);
                        pidx_next = pidx_reg;
                    end
                end
                else if (last_rd)
                begin
                    status_next = ST_MISSING;
                end
            end
            S_SHIFT:
            begin
                if (issue)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pidx_next = idx_reg;
                end
                rd_vld_next = issue && !last_rd;
                if (last_rd)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                end
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

endmodule

// File: hdl/deque_with_search_delete.sv
// Double-ended queue of up to DEPTH signed 32-bit values with search and delete.
// Input channel s_*: s_tuser carries the command (push front, push back,
// delete first match, find), s_tdata the value. Output channel m_*: one
// transfer per command, m_tuser the status (done/found, full, not found),
// m_tdata the zero-based position of a find match, zero otherwise.
// A push, or a find or delete on an empty queue, needs no scan: the sequencer
// goes from idle straight to its result state and hands the result to the output
// register. Find and delete scan the entry ram one read a cycle, stopping at the
// first match or after the last entry. A delete that hits moves each following
// entry up through the one read port and the one write port; no move is needed
// when the match is the last entry.
// One command is in work at a time: s_tready is high only while the sequencer is
// idle, which it is again in the cycle after it hands a result over.
// The output register holds a finished result while m_tready is low, and the
// next command is still accepted and worked on; its result waits until the
// register frees up.
// Reset empties the queue (head and count cleared); ram contents are not
// cleared and need no clearing pass since only written entries are ever read.
// depends on dqsd_pkg, dqsd_ram, dqsd_engine
module deque_with_search_delete #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] position, [7:6] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    import dqsd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;

    dqsd_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser)),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dqsd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register decouples the sequencer from a stalling receiver
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {2'b00, out_reg.position};

`ifndef NO_ASSERTIONS
    // the shift never reads the slot it is writing
    a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("entry ram read and write at the same slot");

    // no new command while a result is still held in the sequencer
    a_busy_while_resp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready)
        else $error("input accepted while a result is pending");

    // output valid only rises after a result transfer from the sequencer
    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("output valid without a result from the sequencer");
`endif

endmodule

// File: tb/deque_with_search_delete_tb.sv
// self-checking testbench for deque_with_search_delete: directed table, then random traffic
// checks each result against a queue-based predictor of the deque or a row's given result
// depends on dqsd_pkg and the deque_with_search_delete rtl
`timescale 1ns / 1ps

module deque_with_search_delete_tb;

    import dqsd_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1875;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_MAX   = 200;
    localparam int TABLE_ROWS   = 24;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] value;
        logic [6:0]  reps;     // row repeated, value incremented each time
        logic        typed;    // expected result given in the row
        status_t     status;
        logic [5:0]  position;
    } table_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] item_value
    logic [1:0]  s_tuser  = '0;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [5:0] position, [7:6] zero
    logic [1:0]  m_tuser;         // [1:0] status

    logic [31:0] stored_values[$];
    res_t        pending_results[$];
    res_t        oldest_result;
    table_row_t  directed_rows[TABLE_ROWS];
    int          mismatches    = 0;
    int          snd_idle_pct  = 6;
    int          rcv_idle_pct  = 46;
    int          quiet_cycles  = 0;
    bit          draining      = 1'b0;

    deque_with_search_delete #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // updates the deque contents for one command and returns its result
    function automatic res_t apply_command(cmd_t c, logic [31:0] v);
        res_t r;
        int   hit;
        r.status   = ST_OK;
        r.position = '0;
        hit        = -1;
        for (int i = 0; i < stored_values.size(); i++)
        begin
            if (hit < 0 && stored_values[i] == v)
                hit = i;
        end
        case (c)
            CMD_PUSH_FRONT:
                if (stored_values.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    stored_values.insert(0, v);
            CMD_PUSH_BACK:
                if (stored_values.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    stored_values.insert(stored_values.size(), v);
            CMD_DELETE:
                if (hit < 0)
                    r.status = ST_MISSING;
                else
                    stored_values.delete(hit);
            default:
                if (hit < 0)
                    r.status = ST_MISSING;
                else
                    r.position = POS_W'(hit);
        endcase
        return r;
    endfunction

    // values already stored most often, some small values in -8..7, some extremes, rest random
    function automatic logic [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && stored_values.size() > 0)
            return stored_values[$urandom_range(0, stored_values.size() - 1)];
        if (r < 70)
            return ($urandom_range(0, 1) ? 32'hFFFF_FFF8 : 32'h0) | $urandom_range(0, 7);
        if (r < 75)
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic cmd_t pick_command();
        int r;
        if (stored_values.size() == DEPTH && $urandom_range(0, 99) < 30)
            draining = 1'b1;
        else if (stored_values.size() == 0 && $urandom_range(0, 99) < 30)
            draining = 1'b0;
        else if ($urandom_range(0, 99) < 2)
            draining = !draining;
        r = $urandom_range(0, 99);
        if (!draining)
        begin
            if (r < 40) return CMD_PUSH_BACK;
            if (r < 70) return CMD_PUSH_FRONT;
            if (r < 80) return CMD_DELETE;
            return CMD_FIND;
        end
        if (r < 15) return CMD_PUSH_BACK;
        if (r < 25) return CMD_PUSH_FRONT;
        if (r < 75) return CMD_DELETE;
        return CMD_FIND;
    endfunction

    task automatic send_command(input cmd_t c, input logic [31:0] v,
                                input bit typed, input res_t typed_res);
        res_t predicted;
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        predicted = apply_command(c, v);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    endtask

    function automatic void note_mismatch(string what, logic [31:0] e, logic [31:0] a);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, e, a);
    endfunction

    // result side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch("unexpected result, status", 32'h0, 32'(m_tuser));
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tuser !== oldest_result.status)
                    note_mismatch("status", 32'(oldest_result.status), 32'(m_tuser));
                if (m_tdata !== {2'b00, oldest_result.position})
                    note_mismatch("position", 32'(oldest_result.position), 32'(m_tdata));
            end
        end
        m_tready <= rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        directed_rows = '{
            '{CMD_DELETE,     32'h0000_0005, 7'd1,  1'b1, ST_MISSING, 6'd0},
            '{CMD_FIND,       32'h0000_0005, 7'd1,  1'b1, ST_MISSING, 6'd0},
            '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_PUSH_FRONT, 32'h8000_0000, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_PUSH_BACK,  32'h0000_0000, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_FIND,       32'h8000_0000, 7'd1,  1'b1, ST_OK,      6'd0},
            '{CMD_FIND,       32'h0000_0000, 7'd1,  1'b0, ST_OK,      6'd0},
            // delete at the head
            '{CMD_DELETE,     32'h8000_0000, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_FIND,       32'h7FFF_FFFF, 7'd1,  1'b0, ST_OK,      6'd0},
            // duplicate value: only the first match goes
            '{CMD_PUSH_FRONT, 32'h0000_0000, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_DELETE,     32'h0000_0000, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_FIND,       32'h0000_0000, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_DELETE,     32'h1234_5678, 7'd1,  1'b1, ST_MISSING, 6'd0},
            // fill up to DEPTH entries
            '{CMD_PUSH_BACK,  32'h55AA_0000, 7'd61, 1'b0, ST_OK,      6'd0},
            '{CMD_PUSH_FRONT, 32'h0000_0001, 7'd1,  1'b1, ST_FULL,    6'd0},
            '{CMD_PUSH_BACK,  32'h0000_0001, 7'd1,  1'b1, ST_FULL,    6'd0},
            '{CMD_FIND,       32'h55AA_003C, 7'd1,  1'b1, ST_OK,      6'd63},
            '{CMD_DELETE,     32'h7FFF_FFFF, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_DELETE,     32'h55AA_003C, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_DELETE,     32'h55AA_0010, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_FIND,       32'h55AA_0011, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_PUSH_FRONT, 32'hA5A5_A5A5, 7'd1,  1'b0, ST_OK,      6'd0},
            '{CMD_FIND,       32'hA5A5_A5A5, 7'd1,  1'b0, ST_OK,      6'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_command(directed_rows[r].cmd, directed_rows[r].value + k,
                             directed_rows[r].typed,
                             '{directed_rows[r].status, directed_rows[r].position});
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                snd_idle_pct = 46;
                rcv_idle_pct = 6;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                // hold off until the deque has answered everything so far
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            send_command(pick_command(), pick_operand(), 1'b0, '{ST_OK, 6'd0});
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: deque_with_search_delete.f
hdl/dqsd_pkg.sv
hdl/dqsd_ram.sv
hdl/dqsd_engine.sv
hdl/deque_with_search_delete.sv
tb/deque_with_search_delete_tb.sv
